// File: rtl/sczs_pkg.sv
package sczs_pkg;

	// Coordinate word and the widths that grow from it
	localparam int COORD_W = 32;
	localparam int RADIUS_W = COORD_W - 1;
	localparam int DIFF_W = COORD_W + 2;      // a - b + c of three coordinates
	localparam int ZD_W = COORD_W + 1;        // difference of two coordinates
	localparam int MAG_W = COORD_W + 1;       // magnitude of an x or y offset
	localparam int SQ_W = 2 * MAG_W;          // square of a magnitude
	localparam int DD_W = SQ_W + 1;           // sum of two squares
	localparam int RAD_W = 2 * COORD_W;       // radicand, also R^2
	localparam int ROOT_W = COORD_W;          // integer square root
	localparam int REM_W = ROOT_W + 2;        // partial remainder of the root
	localparam int Z_W = COORD_W + 3;         // unclamped z result
	localparam int SQ_LO_W = MAG_W / 2;       // low part of a split square
	localparam int SQ_HI_W = MAG_W - SQ_LO_W; // high part of a split square

	localparam logic [COORD_W-1:0] Z_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] Z_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] target_x;
		logic signed [COORD_W-1:0] target_y;
		logic signed [COORD_W-1:0] target_z;
		logic [RADIUS_W-1:0] target_radius;
		logic signed [COORD_W-1:0] bullet_x;
		logic signed [COORD_W-1:0] bullet_y;
		logic signed [COORD_W-1:0] bullet_z;
		logic [RADIUS_W-1:0] bullet_radius;
		logic signed [COORD_W-1:0] shift_x;
		logic signed [COORD_W-1:0] shift_y;
	} sczs_in_t;

	typedef struct packed {
		logic hit;
		logic signed [COORD_W-1:0] z_shift;
		logic saturated;
	} sczs_out_t;

	// Data that rides alongside the square root pipeline
	typedef struct packed {
		logic hit;
		logic signed [ZD_W-1:0] zd;
	} sczs_side_t;

endpackage

// File: rtl/sphere_contact_z_shift.sv
// Sphere contact along z. Each input word holds a target sphere, a bullet
// sphere and an x-y shift for the bullet, all signed Q16.16 (radii unsigned).
// The result word gives hit, the z displacement at which the shifted bullet
// first touches the target (-zd - floor(sqrt(R^2 - xd^2 - yd^2))), and a flag
// when that value was clamped to the 32-bit range. With no contact, hit is
// low and z_shift is the largest positive value, with saturated low.
// The block is fully pipelined: one word enters per cycle while the result
// side is not stalled, and results leave in the order their words came.
// Six stages form the offsets, the squares (as 17x17, 17x16 and 16x16
// products) and the discriminant; a 32-stage digit-by-digit square root
// follows, one root bit per stage; a last stage clamps into the output
// register. A stall on the result side freezes the whole pipeline, so
// item_stall is high exactly while a result is held and stalled.
module sphere_contact_z_shift (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  sczs_pkg::sczs_in_t item,
	output logic result_valid,
	input  logic result_stall,
	output sczs_pkg::sczs_out_t result
);
	import sczs_pkg::*;

	logic adv;

	// Stage 1: center offsets and radius sum
	logic v_s1;
	logic signed [DIFF_W-1:0] xd_s1, yd_s1;
	logic signed [ZD_W-1:0] zd_s1;
	logic [COORD_W-1:0] sumr_s1;

	// Stage 2: magnitudes
	logic v_s2;
	logic [MAG_W-1:0] magx_s2, magy_s2, sumr_s2;
	logic signed [ZD_W-1:0] zd_s2;

	// Stages 3 and 4: squarers, zd and valid follow alongside
	logic v_s3, v_s4;
	logic signed [ZD_W-1:0] zd_s3, zd_s4;
	logic [SQ_W-1:0] sqx, sqy, sqr;

	// Stage 5: sum of squares
	logic v_s5;
	logic [DD_W-1:0] dd_s5;
	logic [RAD_W-1:0] rr_s5;
	logic signed [ZD_W-1:0] zd_s5;

	// Stage 6: discriminant
	logic v_s6;
	logic [RAD_W-1:0] s_s6;
	sczs_side_t side_s6;
	logic [DD_W:0] diff;

	// Square root output and final clamp
	logic root_valid;
	logic [ROOT_W-1:0] root;
	sczs_side_t root_side;
	logic [Z_W-1:0] zd_ext, root_ext, z_full;
	logic z_ovf;
	sczs_out_t res_d;

	logic result_valid_q;
	sczs_out_t result_q;

	// Advance everything unless a finished word is held by the consumer
	assign adv = !(result_valid_q && result_stall);
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			result_valid_q <= root_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xd_s1 <= DIFF_W'(item.bullet_x) - DIFF_W'(item.target_x) + DIFF_W'(item.shift_x);
			yd_s1 <= DIFF_W'(item.bullet_y) - DIFF_W'(item.target_y) + DIFF_W'(item.shift_y);
			zd_s1 <= ZD_W'(item.bullet_z) - ZD_W'(item.target_z);
			sumr_s1 <= {1'b0, item.target_radius} + {1'b0, item.bullet_radius};

			magx_s2 <= xd_s1[DIFF_W-1] ? MAG_W'(-xd_s1) : MAG_W'(xd_s1);
			magy_s2 <= yd_s1[DIFF_W-1] ? MAG_W'(-yd_s1) : MAG_W'(yd_s1);
			sumr_s2 <= {{(MAG_W-COORD_W){1'b0}}, sumr_s1};
			zd_s2 <= zd_s1;

			zd_s3 <= zd_s2;
			zd_s4 <= zd_s3;

			dd_s5 <= {1'b0, sqx} + {1'b0, sqy};
			rr_s5 <= sqr[RAD_W-1:0];
			zd_s5 <= zd_s4;

			s_s6 <= diff[RAD_W-1:0];
			side_s6.hit <= !diff[DD_W];
			side_s6.zd <= zd_s5;

			result_q <= res_d;
		end
	end

	sczs_sqr u_sqr_x (.clk(clk), .adv(adv), .mag(magx_s2), .sq(sqx));
	sczs_sqr u_sqr_y (.clk(clk), .adv(adv), .mag(magy_s2), .sq(sqy));
	sczs_sqr u_sqr_r (.clk(clk), .adv(adv), .mag(sumr_s2), .sq(sqr));

	// S = R^2 - xd^2 - yd^2; the sign bit decides contact
	assign diff = {{(DD_W+1-RAD_W){1'b0}}, rr_s5} - {1'b0, dd_s5};

	sczs_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_in(v_s6),
		.radicand(s_s6),
		.side_in(side_s6),
		.valid_out(root_valid),
		.root(root),
		.side_out(root_side)
	);

	// z = -zd - root, then clamp to the signed coordinate range
	assign zd_ext = {{(Z_W-ZD_W){root_side.zd[ZD_W-1]}}, root_side.zd};
	assign root_ext = {{(Z_W-ROOT_W){1'b0}}, root};
	assign z_full = -zd_ext - root_ext;
	assign z_ovf = !((&z_full[Z_W-1:COORD_W-1]) || !(|z_full[Z_W-1:COORD_W-1]));

	always_comb begin
		res_d.hit = root_side.hit;
		res_d.saturated = 1'b0;
		res_d.z_shift = Z_MAX;
		if (root_side.hit) begin
			if (z_ovf) begin
				res_d.saturated = 1'b1;
				res_d.z_shift = z_full[Z_W-1] ? Z_MIN : Z_MAX;
			end else begin
				res_d.z_shift = z_full[COORD_W-1:0];
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// A miss always reports the far value and never the clamp flag
	a_miss_far: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.z_shift == Z_MAX && !result.saturated)
		else $error("miss without far z value");

	// A clamp only happens on a hit and lands on one end of the range
	a_sat_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
			result.hit && (result.z_shift == Z_MAX || result.z_shift == Z_MIN))
		else $error("clamp flag with in-range value");

	// Hold the root pipeline output while the consumer stalls
	a_root_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(root_valid) && (!root_valid || $stable(root)))
		else $error("root pipeline moved during stall");

endmodule

// File: rtl/sczs_sqr.sv
module sczs_sqr (
	input  logic clk,
	input  logic adv,
	input  logic [sczs_pkg::MAG_W-1:0] mag,
	output logic [sczs_pkg::SQ_W-1:0] sq
);
	import sczs_pkg::*;

	logic [SQ_HI_W-1:0] hi;
	logic [SQ_LO_W-1:0] lo;
	logic [2*SQ_HI_W-1:0] hh_s1;
	logic [SQ_HI_W+SQ_LO_W-1:0] hl_s1;
	logic [2*SQ_LO_W-1:0] ll_s1;
	logic [SQ_W-1:0] sq_s2;

	assign hi = mag[MAG_W-1:SQ_LO_W];
	assign lo = mag[SQ_LO_W-1:0];

	// Split the square into three narrow products, then sum them
	always_ff @(posedge clk) begin
		if (adv) begin
			hh_s1 <= (2 * SQ_HI_W)'(hi * hi);
			hl_s1 <= (SQ_HI_W + SQ_LO_W)'(hi * lo);
			ll_s1 <= (2 * SQ_LO_W)'(lo * lo);
			sq_s2 <= (SQ_W'(hh_s1) << (2 * SQ_LO_W)) + (SQ_W'(hl_s1) << (SQ_LO_W + 1))
				+ SQ_W'(ll_s1);
		end
	end

	assign sq = sq_s2;

endmodule

// File: rtl/sczs_sqrt.sv
module sczs_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_in,
	input  logic [sczs_pkg::RAD_W-1:0] radicand,
	input  sczs_pkg::sczs_side_t side_in,
	output logic valid_out,
	output logic [sczs_pkg::ROOT_W-1:0] root,
	output sczs_pkg::sczs_side_t side_out
);
	import sczs_pkg::*;

	logic v_s [1:ROOT_W];
	logic [REM_W-1:0] rem_s [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [RAD_W-1:0] rad_s [1:ROOT_W];
	sczs_side_t side_s [1:ROOT_W];

	// One root bit per stage, two radicand bits consumed per stage
	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		logic v_prev;
		logic [REM_W-1:0] rem_prev;
		logic [ROOT_W-1:0] root_prev;
		logic [RAD_W-1:0] rad_prev;
		sczs_side_t side_prev;
		logic [REM_W-1:0] rem_shift;
		logic [REM_W-1:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign v_prev = valid_in;
			assign rem_prev = '0;
			assign root_prev = '0;
			assign rad_prev = radicand;
			assign side_prev = side_in;
		end else begin : g_next
			assign v_prev = v_s[i];
			assign rem_prev = rem_s[i];
			assign root_prev = root_s[i];
			assign rad_prev = rad_s[i];
			assign side_prev = side_s[i];
		end

		assign rem_shift = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
		assign trial = {root_prev, 2'b01};
		assign ge = (rem_shift >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? rem_shift - trial : rem_shift;
				root_s[i+1] <= {root_prev[ROOT_W-2:0], ge};
				rad_s[i+1] <= rad_prev << 2;
				side_s[i+1] <= side_prev;
			end
		end
	end

	assign valid_out = v_s[ROOT_W];
	assign root = root_s[ROOT_W];
	assign side_out = side_s[ROOT_W];

endmodule

// File: test/tb_sphere_contact_z_shift.sv
`timescale 1ns / 100ps

module tb_sphere_contact_z_shift;

	import sczs_pkg::*;

	// Handy Q16.16 values for the directed table
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
	localparam logic [31:0] MINC = 32'h8000_0000;
	localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

	// One row of the directed table. Where typed is set, want holds the
	// result read straight off the geometry; otherwise the predictor decides.
	typedef struct {
		sczs_in_t w;
		bit typed;
		sczs_out_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	sczs_in_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	sczs_out_t result;

	// Results still owed by the block, oldest first
	sczs_out_t contacts_owed[$];
	stim_row_t directed_rows[$];
	int mismatches = 0;
	// Idle odds: 0 means no idling, n means one chance in n per word or cycle
	int gap_odds = 0;
	int stall_odds = 0;
	int stall_left = 0;

	sphere_contact_z_shift i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	// Work out the contact result of one word with exact wide integers.
	// Offsets fit easily in 128 bits, squares too; only the root rounds (floor).
	function automatic sczs_out_t contact_of(sczs_in_t w);
		logic signed [127:0] xd, yd, zd, sum_r, r_sq, d_sq, radicand, root, cand, z, lim;
		sczs_out_t res;
		xd = 128'(w.bullet_x) - 128'(w.target_x) + 128'(w.shift_x);
		yd = 128'(w.bullet_y) - 128'(w.target_y) + 128'(w.shift_y);
		zd = 128'(w.bullet_z) - 128'(w.target_z);
		sum_r = {97'b0, w.target_radius};
		sum_r = sum_r + {97'b0, w.bullet_radius};
		r_sq = sum_r * sum_r;
		d_sq = xd * xd + yd * yd;
		lim = 128'sd1 <<< (COORD_W - 1);
		res.hit = 1'b0;
		res.z_shift = Z_MAX;
		res.saturated = 1'b0;
		if (d_sq <= r_sq) begin
			radicand = r_sq - d_sq;
			root = '0;
			// Build the root one bit at a time, keeping a bit when its square still fits
			for (int i = ROOT_W - 1; i >= 0; i--) begin
				cand = root | (128'sd1 <<< i);
				if (cand * cand <= radicand)
					root = cand;
			end
			z = -zd - root;
			res.hit = 1'b1;
			if (z >= lim) begin
				res.z_shift = Z_MAX;
				res.saturated = 1'b1;
			end else if (z < -lim) begin
				res.z_shift = Z_MIN;
				res.saturated = 1'b1;
			end else begin
				res.z_shift = z[COORD_W-1:0];
			end
		end
		return res;
	endfunction

	function automatic stim_row_t row(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
			logic [31:0] tr, logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
			logic [31:0] br, logic [31:0] sx, logic [31:0] sy, bit typed,
			sczs_out_t want);
		stim_row_t r;
		r.w.target_x = tx;
		r.w.target_y = ty;
		r.w.target_z = tz;
		r.w.target_radius = RADIUS_W'(tr);
		r.w.bullet_x = bx;
		r.w.bullet_y = by;
		r.w.bullet_z = bz;
		r.w.bullet_radius = RADIUS_W'(br);
		r.w.shift_x = sx;
		r.w.shift_y = sy;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Pick one of the awkward values of a coordinate word
	function automatic logic [31:0] corner_value();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return ALL1;
			2: return MINC;
			3: return MAXC;
			default: return $urandom;
		endcase
	endfunction

	// Present one word, hold it until taken, then log what it must produce.
	// Drop valid for a short burst now and then to put gaps in the stream.
	task automatic send_word(sczs_in_t w, bit typed, sczs_out_t want);
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		contacts_owed.push_back(typed ? want : contact_of(w));
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Result side: check each accepted word against the oldest prediction,
	// then decide whether to stall the next cycle.
	always @(posedge clk) begin
		sczs_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (contacts_owed.size() == 0) begin
				$error("result word with no prediction waiting");
				mismatches++;
			end else begin
				want = contacts_owed.pop_front();
				if (result.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, result.hit);
					mismatches++;
				end
				if (result.z_shift !== want.z_shift) begin
					$error("z_shift: expected %0d, got %0d", want.z_shift, result.z_shift);
					mismatches++;
				end
				if (result.saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d", want.saturated,
						result.saturated);
					mismatches++;
				end
			end
		end
		// Stall in bursts counted down by stall_left; no new burst starts while the odds are zero
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			result_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		sczs_in_t w;
		int mode;
		int unsigned r1, r2, span;
		int dx, dy, dz;

		// Directed table: extremes, touching, no contact, clamping both ways
		// All zero: the spheres coincide with zero radius, touch at zero shift
		directed_rows.push_back(row('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1,
			{1'b1, 32'h0, 1'b0}));
		// Unit spheres far apart in x: no contact, largest positive value
		directed_rows.push_back(row('0, '0, '0, ONE, 16 * ONE, '0, '0, ONE, '0, '0, 1'b1,
			{1'b0, Z_MAX, 1'b0}));
		// Unit spheres exactly side by side: grazing contact at zero shift
		directed_rows.push_back(row('0, '0, '0, ONE, 2 * ONE, '0, '0, ONE, '0, '0, 1'b1,
			{1'b1, 32'h0, 1'b0}));
		// Bullet far below the target: clamp high
		directed_rows.push_back(row('0, '0, MAXC, '0, '0, '0, MINC, '0, '0, '0, 1'b1,
			{1'b1, Z_MAX, 1'b1}));
		// Bullet far above the target: clamp low
		directed_rows.push_back(row('0, '0, MINC, '0, '0, '0, MAXC, '0, '0, '0, 1'b1,
			{1'b1, Z_MIN, 1'b1}));
		// Largest radii at one centre: root overflows downward
		directed_rows.push_back(row('0, '0, '0, MAXC, '0, '0, '0, MAXC, '0, '0, 1'b1,
			{1'b1, Z_MIN, 1'b1}));
		// Huge z gap but no contact: no clamp flag
		directed_rows.push_back(row('0, '0, MAXC, '0, ONE, '0, MINC, '0, '0, '0, 1'b1,
			{1'b0, Z_MAX, 1'b0}));
		// The rest go through the predictor
		directed_rows.push_back(row('0, '0, MAXC, MAXC, '0, '0, MINC, MAXC, '0, '0, 1'b0,
			'0));
		directed_rows.push_back(row(MINC, MAXC, '0, MAXC, MAXC, MINC, '0, MAXC, MAXC, MINC,
			1'b0, '0));
		directed_rows.push_back(row(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
			MAXC, 1'b0, '0));
		directed_rows.push_back(row(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
			MINC, 1'b0, '0));
		directed_rows.push_back(row(ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1,
			ALL1, 1'b0, '0));
		directed_rows.push_back(row('0, '0, '0, ONE, ONE / 2, '0, 5 * ONE, ONE, '0, '0,
			1'b0, '0));
		// Shift pulls a distant bullet back into contact
		directed_rows.push_back(row('0, '0, '0, 3 * ONE / 2, 100 * ONE, -3 * ONE, -7 * ONE,
			3 * ONE / 2, -100 * ONE + ONE / 4, 3 * ONE, 1'b0, '0));
		// Tiny radii, the first where the root must round down
		directed_rows.push_back(row('0, '0, '0, 32'h1, 32'h1, '0, '0, 32'h2, '0, '0, 1'b0,
			'0));
		directed_rows.push_back(row('0, '0, '0, 32'h1, 32'h1, '0, ALL1, '0, '0, '0, 1'b0,
			'0));
		directed_rows.push_back(row(ONE, 5 * ONE, -2 * ONE, 2 * ONE, ONE, '0, 3 * ONE,
			ONE, '0, 5 * ONE, 1'b0, '0));

		// Hold reset, then release it on a clock edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_odds = 3;
		stall_odds = 4;
		foreach (directed_rows[k])
			send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].want);

		// Hold off until the pipeline has drained every owed result
		item_valid <= 1'b0;
		while (contacts_owed.size() != 0)
			@(posedge clk);

		for (int n = 0; n < 1200; n++) begin
			// Alternate busy and calm stretches; keep the tail free of idling
			if (n >= 1000 || (n / 150) % 2 == 1) begin
				gap_odds = 0;
				stall_odds = 0;
			end else begin
				gap_odds = 2 + (n / 300);
				stall_odds = 3;
			end
			mode = $urandom_range(0, 9);
			w = '0;
			if (mode < 2) begin
				// Fully random words: every bit of every field
				w.target_x = $urandom;
				w.target_y = $urandom;
				w.target_z = $urandom;
				w.target_radius = RADIUS_W'($urandom);
				w.bullet_x = $urandom;
				w.bullet_y = $urandom;
				w.bullet_z = $urandom;
				w.bullet_radius = RADIUS_W'($urandom);
				w.shift_x = $urandom;
				w.shift_y = $urandom;
			end else if (mode < 7) begin
				// Near contact: place the shifted bullet within reach of the target
				r1 = $urandom_range(0, 1 << 27);
				r2 = $urandom_range(0, 1 << 27);
				span = r1 + r2;
				dx = int'($urandom_range(0, 2 * span)) - int'(span);
				dy = int'($urandom_range(0, 2 * span)) - int'(span);
				dz = int'($urandom_range(0, 1 << 29)) - (1 << 28);
				w.target_x = $urandom_range(0, 1 << 29) - (1 << 28);
				w.target_y = $urandom_range(0, 1 << 29) - (1 << 28);
				w.target_z = $urandom_range(0, 1 << 29) - (1 << 28);
				w.shift_x = $urandom_range(0, 1 << 29) - (1 << 28);
				w.shift_y = $urandom_range(0, 1 << 29) - (1 << 28);
				w.target_radius = RADIUS_W'(r1);
				w.bullet_radius = RADIUS_W'(r2);
				w.bullet_x = w.target_x - w.shift_x + dx;
				w.bullet_y = w.target_y - w.shift_y + dy;
				w.bullet_z = w.target_z + dz;
			end else if (mode < 9) begin
				// Small scenes, every field within 16 units of zero
				w.target_x = $urandom_range(0, 1 << 21) - (1 << 20);
				w.target_y = $urandom_range(0, 1 << 21) - (1 << 20);
				w.target_z = $urandom_range(0, 1 << 21) - (1 << 20);
				w.target_radius = RADIUS_W'($urandom_range(0, 1 << 20));
				w.bullet_x = $urandom_range(0, 1 << 21) - (1 << 20);
				w.bullet_y = $urandom_range(0, 1 << 21) - (1 << 20);
				w.bullet_z = $urandom_range(0, 1 << 21) - (1 << 20);
				w.bullet_radius = RADIUS_W'($urandom_range(0, 1 << 20));
				w.shift_x = $urandom_range(0, 1 << 21) - (1 << 20);
				w.shift_y = $urandom_range(0, 1 << 21) - (1 << 20);
			end else begin
				// Corner values mixed with random ones
				w.target_x = corner_value();
				w.target_y = corner_value();
				w.target_z = corner_value();
				w.target_radius = RADIUS_W'(corner_value());
				w.bullet_x = corner_value();
				w.bullet_y = corner_value();
				w.bullet_z = corner_value();
				w.bullet_radius = RADIUS_W'(corner_value());
				w.shift_x = corner_value();
				w.shift_y = corner_value();
			end
			send_word(w, 1'b0, '0);
		end

		// Drain, then give the pipeline time to show any stray result
		item_valid <= 1'b0;
		while (contacts_owed.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
